// ----- rtl/fen_pkg.sv -----
// ----------------------------------------------------------------------------
// fen_pkg
// Shared types and codes for the binary indexed tree block: request and
// response payloads, request modes and the operation codes of the shared adder.
// ----------------------------------------------------------------------------
package fen_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 16;
   localparam int unsigned LEN_W  = 17;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_CLEAR = 2'd0;
   localparam mode_type MODE_TAKE  = 2'd1;
   localparam mode_type MODE_ADD   = 2'd2;
   localparam mode_type MODE_RANGE = 2'd3;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type        op;
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
   } alu_in_type;

   typedef struct packed {
      mode_type                 mode;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         upper_position;
      logic signed [DATA_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] answer;
      logic                     is_range_sum;
   } rsp_type;

endpackage

// ----- rtl/fen_ram.sv -----
// ----------------------------------------------------------------------------
// fen_ram
// Simple dual-port memory: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module fen_ram #(
   parameter int DEPTH = 65536,
   parameter int AW    = 16,
   parameter int DW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/fen_alu.sv -----
// ----------------------------------------------------------------------------
// fen_alu
// The one 32-bit adder/subtractor shared by the arithmetic steps of the sequencer.
// ----------------------------------------------------------------------------
module fen_alu (
   input  fen_pkg::alu_in_type            alu_in,
   output logic [fen_pkg::DATA_W-1:0]     alu_out
);

   import fen_pkg::*;

   always_comb begin
      case (alu_in.op)
         ALU_ADD: alu_out = alu_in.a + alu_in.b;
         ALU_SUB: alu_out = alu_in.a - alu_in.b;
         default: alu_out = alu_in.a + alu_in.b;
      endcase
   end

endmodule

// ----- rtl/fenwick_point_update_range_sum.sv -----
// ----------------------------------------------------------------------------
// fenwick_point_update_range_sum
// Binary indexed tree with clear, point update, take-all and range sum over signed
// 32-bit values, built around one shared adder and a small sequencer.
// ----------------------------------------------------------------------------
//
// Channel   Ports                           Direction  Handshake
// request   start, busy, req_data           in         accepted when start & !busy
// response  rsp_strobe, rsp_data            out        one-cycle strobe, no back-pressure
// control   csr_valid, csr_ready, csr_data  in         written when csr_valid & csr_ready
//
// Steps: an add or take-all reads the position value, then reads and
// writes each tree node on its upward walk; a range sum walks two prefixes
// of at most log2(SIZE+1) nodes each; a clear zeroes every entry. Each node
// visit uses the single tree read port and the one shared adder.
// Reset starts the same clearing pass, with busy held high.
// The control register is taken in any cycle; responses cannot be stalled.
// ----------------------------------------------------------------------------
module fenwick_point_update_range_sum #(
   parameter int SIZE = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  fen_pkg::req_type           req_data,
   output logic                       rsp_strobe,
   output fen_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [fen_pkg::LEN_W-1:0]  csr_data
);

   import fen_pkg::*;

   // Address width of the memories, and width of a tree index. A tree index
   // runs from 1 to the position count and may step just past it, so it
   // carries one spare bit above what SIZE itself needs.
   localparam int AW    = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int NW    = $clog2(SIZE + 1) + 1;
   localparam int N_RST = (SIZE < 65536) ? SIZE : 65536;

   typedef enum logic [6:0] {
      S_CLEAR   = 7'b0000001,
      S_IDLE    = 7'b0000010,
      S_VAL_RD  = 7'b0000100,
      S_NODE_RD = 7'b0001000,
      S_NODE_WR = 7'b0010000,
      S_SUM_RD  = 7'b0100000,
      S_SUM_ACC = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [NW-1:0]      k_ff, k_in;
   logic [NW-1:0]      n_ff, n_in;
   logic [DATA_W-1:0]  delta_ff, delta_in;
   logic [DATA_W-1:0]  sum_ff, sum_in;
   logic               pass2_ff, pass2_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               accept;
   logic [NW-1:0]      k_low;
   logic [NW-1:0]      k_up;
   logic [NW-1:0]      k_dn;
   logic [NW-1:0]      k_m1;
   logic [AW-1:0]      tree_idx;
   logic [AW-1:0]      pos_idx;
   logic               req_in_range;

   logic               val_we;
   logic [AW-1:0]      val_waddr;
   logic [DATA_W-1:0]  val_wdata;
   logic [DATA_W-1:0]  val_rdata;
   logic               tree_we;
   logic [AW-1:0]      tree_waddr;
   logic [DATA_W-1:0]  tree_wdata;
   logic [DATA_W-1:0]  tree_rdata;

   alu_in_type         alu_in;
   logic [DATA_W-1:0]  alu_out;

   fen_ram #(.DEPTH(SIZE), .AW(AW), .DW(DATA_W)) u_values (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (val_waddr),
      .wr_data (val_wdata),
      .rd_addr (pos_idx),
      .rd_data (val_rdata)
   );

   fen_ram #(.DEPTH(SIZE), .AW(AW), .DW(DATA_W)) u_tree (
      .clock   (clock),
      .wr_en   (tree_we),
      .wr_addr (tree_waddr),
      .wr_data (tree_wdata),
      .rd_addr (tree_idx),
      .rd_data (tree_rdata)
   );

   fen_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign csr_ready  = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // Lowest set bit of the current tree index, and the two neighbours the
   // walks move to: upwards for an update, downwards for a prefix sum.
   assign k_low    = k_ff & (~k_ff + NW'(1));
   assign k_up     = k_ff + k_low;
   assign k_dn     = k_ff - k_low;
   assign k_m1     = k_ff - NW'(1);
   assign tree_idx = k_m1[AW-1:0];

   // The value memory is read straight from the request port, so the value
   // is ready in the cycle after acceptance.
   assign pos_idx      = AW'(req_data.position);
   assign req_in_range = 32'(req_data.position) < 32'(SIZE);

   // Effective position count: the written length held to 1..SIZE.
   always_comb begin
      n_in = n_ff;
      if (csr_valid && csr_ready) begin
         if (csr_data == '0) begin
            n_in = NW'(1);
         end else if (32'(csr_data) > 32'(SIZE)) begin
            n_in = NW'(SIZE);
         end else begin
            n_in = NW'(csr_data);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      k_in          = k_ff;
      delta_in      = delta_ff;
      sum_in        = sum_ff;
      pass2_in      = pass2_ff;
      clr_in        = clr_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      val_we     = 1'b0;
      val_waddr  = AW'(req_ff.position);
      val_wdata  = '0;
      tree_we    = 1'b0;
      tree_waddr = tree_idx;
      tree_wdata = alu_out;

      alu_in.op = ALU_ADD;
      alu_in.a  = '0;
      alu_in.b  = '0;

      case (state_ff)
         S_CLEAR: begin
            // Both memories are zeroed together, one entry per cycle.
            val_we     = 1'b1;
            val_waddr  = clr_ff;
            tree_we    = 1'b1;
            tree_waddr = clr_ff;
            tree_wdata = '0;
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(SIZE - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.mode)
                  MODE_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLEAR;
                  end
                  MODE_TAKE, MODE_ADD: begin
                     if (req_in_range) begin
                        state_in = S_VAL_RD;
                     end else if (req_data.mode == MODE_TAKE) begin
                        // A position beyond the memories reads as zero.
                        rsp_strobe_in       = 1'b1;
                        rsp_in.answer       = '0;
                        rsp_in.is_range_sum = 1'b0;
                     end
                  end
                  MODE_RANGE: begin
                     // First prefix ends at the upper bound, held below n.
                     if (32'(req_data.upper_position) < 32'(n_ff)) begin
                        k_in = NW'(req_data.upper_position) + NW'(1);
                     end else begin
                        k_in = n_ff;
                     end
                     sum_in   = '0;
                     pass2_in = 1'b0;
                     state_in = S_SUM_RD;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_VAL_RD: begin
            // The position value is here; update it and set up the tree walk.
            val_we = 1'b1;
            if (req_ff.mode == MODE_ADD) begin
               alu_in.op = ALU_ADD;
               alu_in.a  = val_rdata;
               alu_in.b  = req_ff.amount;
               val_wdata = alu_out;
               delta_in  = req_ff.amount;
            end else begin
               alu_in.op = ALU_SUB;
               alu_in.a  = '0;
               alu_in.b  = val_rdata;
               val_wdata = '0;
               delta_in  = alu_out;
               sum_in    = val_rdata;
            end
            k_in = NW'(req_ff.position) + NW'(1);
            if (NW'(req_ff.position) + NW'(1) <= n_ff) begin
               state_in = S_NODE_RD;
            end else begin
               // Positions past the tree only change their own value.
               state_in = S_IDLE;
               if (req_ff.mode == MODE_TAKE) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.answer       = val_rdata;
                  rsp_in.is_range_sum = 1'b0;
               end
            end
         end

         S_NODE_RD: begin
            state_in = S_NODE_WR;
         end

         S_NODE_WR: begin
            alu_in.op = ALU_ADD;
            alu_in.a  = tree_rdata;
            alu_in.b  = delta_ff;
            tree_we   = 1'b1;
            k_in      = k_up;
            if (k_up <= n_ff) begin
               state_in = S_NODE_RD;
            end else begin
               state_in = S_IDLE;
               if (req_ff.mode == MODE_TAKE) begin
                  rsp_strobe_in       = 1'b1;
                  rsp_in.answer       = sum_ff;
                  rsp_in.is_range_sum = 1'b0;
               end
            end
         end

         S_SUM_RD: begin
            state_in = S_SUM_ACC;
         end

         S_SUM_ACC: begin
            // The first prefix is added, the second (below the lower bound)
            // is subtracted from the running total.
            alu_in.op = pass2_ff ? ALU_SUB : ALU_ADD;
            alu_in.a  = sum_ff;
            alu_in.b  = tree_rdata;
            sum_in    = alu_out;
            if (k_dn != '0) begin
               k_in     = k_dn;
               state_in = S_SUM_RD;
            end else if (!pass2_ff && (req_ff.position != '0)) begin
               pass2_in = 1'b1;
               if (32'(req_ff.position) < 32'(n_ff)) begin
                  k_in = NW'(req_ff.position);
               end else begin
                  k_in = n_ff;
               end
               state_in = S_SUM_RD;
            end else begin
               rsp_strobe_in       = 1'b1;
               rsp_in.answer       = alu_out;
               rsp_in.is_range_sum = 1'b1;
               state_in            = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         n_ff          <= NW'(N_RST);
         rsp_strobe_ff <= 1'b0;
         pass2_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         n_ff          <= n_in;
         rsp_strobe_ff <= rsp_strobe_in;
         pass2_ff      <= pass2_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      k_ff     <= k_in;
      delta_ff <= delta_in;
      sum_ff   <= sum_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ----- rtl/fen_check.sv -----
// ----------------------------------------------------------------------------
// fen_check
// Port-level checks on the binary indexed tree block, bound to its top level.
// ----------------------------------------------------------------------------
module fen_check (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  fen_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  fen_pkg::rsp_type  rsp_data
);

   import fen_pkg::*;

   // The clearing pass after reset keeps the block busy.
   a_busy_after_reset: assert property (@(posedge clock)
      disable iff (reset) $past(reset) |-> busy)
      else $error("block not busy after reset");

   // A clear request always starts a sweep.
   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_CLEAR) |=> busy)
      else $error("clear request did not start a sweep");

   // No response follows directly on an accepted add request.
   a_add_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_ADD) |=> !rsp_strobe)
      else $error("response after an add request");

   // A range sum walks at least one node before answering.
   a_range_walks: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.mode == MODE_RANGE) |=> (busy && !rsp_strobe))
      else $error("range sum answered without a walk");

   // A range sum answer only comes out of a walk.
   a_range_from_walk: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_range_sum) |-> $past(busy))
      else $error("range sum answer without a walk");

endmodule

bind fenwick_point_update_range_sum fen_check u_fen_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
